>>> hdl/pws_pkg.sv
// Shared types and constants for the priority wait semaphore.
// Used by pws_queue, pws_ctrl and priority_wait_semaphore; depends on nothing.
package pws_pkg;

	localparam int QUEUE_DEPTH = 16;
	localparam int ID_W        = 6;
	localparam int PRIO_W      = 5;
	localparam int COUNT_W     = 8;
	localparam int IDX_W       = $clog2(QUEUE_DEPTH);
	localparam int TOTAL_W     = IDX_W + 1;

	localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};
	localparam logic [TOTAL_W-1:0] TOTAL_FULL = TOTAL_W'(QUEUE_DEPTH);

	typedef enum logic [1:0] {
		FUNC_PEND     = 2'd0,
		FUNC_TRY_PEND = 2'd1,
		FUNC_POST     = 2'd2,
		FUNC_POST_ALT = 2'd3
	} func_t;

	typedef enum logic [2:0] {
		ST_GRANTED    = 3'd0,
		ST_QUEUED     = 3'd1,
		ST_TRY_FAILED = 3'd2,
		ST_RAISED     = 3'd3,
		ST_WOKEN      = 3'd4,
		ST_FULL       = 3'd5,
		ST_SATURATED  = 3'd6
	} status_t;

	typedef enum logic [1:0] {
		S_IDLE,
		S_INSERT,
		S_COMPACT,
		S_DONE
	} state_t;

	typedef struct packed {
		logic [ID_W-1:0]   id;
		logic [PRIO_W-1:0] prio;
	} waiter_t;

	typedef struct packed {
		logic             en;
		logic [IDX_W-1:0] idx;
		waiter_t          data;
	} q_wr_t;

	typedef struct packed {
		status_t            status;
		waiter_t            woken;
		logic [COUNT_W-1:0] count_now;
		logic [TOTAL_W-1:0] waiters_now;
	} result_t;

endpackage

>>> hdl/priority_wait_semaphore.sv
// Top level of the priority wait semaphore: stream ports, output register,
// sequencer and wait queue. Depends on pws_pkg, pws_queue and pws_ctrl.
//
// Each item is a pend, try-pend or post and yields one result item. Grants,
// failed tries, full-queue rejects and count changes pass from acceptance
// through the done state and the output register. A pend that queues walks
// the queue from the tail, moving one entry per cycle through the single
// priority comparator, past every waiter with a larger priority value. A
// post that wakes a waiter while others remain compacts the queue one entry
// per cycle. The input is not ready while an item is in progress. Writing
// the count register reloads the count and empties the queue.
module priority_wait_semaphore (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [15:0] s_axis_tdata,  // thread_id[5:0], thread_prio[10:6], zero fill
	input  logic [1:0]  s_axis_tuser,  // func[1:0]
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [23:0] m_axis_tdata,  // woken_id[5:0], woken_prio[10:6],
	                                   // count_now[18:11], waiters_now[23:19]
	output logic [2:0]  m_axis_tuser,  // status[2:0]
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [7:0]  cfg_data       // initial_count
);

	logic [pws_pkg::IDX_W-1:0] rd_idx;
	pws_pkg::waiter_t          rd_data;
	pws_pkg::q_wr_t            wr;
	pws_pkg::waiter_t          in_waiter;
	logic                      res_valid;
	logic                      res_ready;
	pws_pkg::result_t          res;
	pws_pkg::result_t          out_q;
	logic                      out_valid_q;

	assign in_waiter.id   = s_axis_tdata[5:0];
	assign in_waiter.prio = s_axis_tdata[10:6];
	assign cfg_ready      = 1'b1;
	assign res_ready      = !out_valid_q || m_axis_tready;

	pws_queue u_queue (
		.clk     (clk),
		.rd_idx  (rd_idx),
		.rd_data (rd_data),
		.wr      (wr)
	);

	pws_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_axis_tvalid),
		.in_ready  (s_axis_tready),
		.in_func   (pws_pkg::func_t'(s_axis_tuser)),
		.in_waiter (in_waiter),
		.cfg_wr    (cfg_valid && cfg_ready),
		.cfg_count (cfg_data),
		.rd_idx    (rd_idx),
		.rd_data   (rd_data),
		.wr        (wr),
		.res_valid (res_valid),
		.res_ready (res_ready),
		.res       (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res_valid && res_ready) begin
			out_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res_valid && res_ready) begin
			out_q <= res;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tuser  = out_q.status;
	assign m_axis_tdata  = {out_q.waiters_now, out_q.count_now,
	                        out_q.woken.prio, out_q.woken.id};

endmodule

>>> hdl/pws_queue.sv
// Wait queue storage: one entry per queued thread, kept in priority order.
// One combinational read port and one write port; depends on pws_pkg.
module pws_queue (
	input  logic                        clk,
	input  logic [pws_pkg::IDX_W-1:0]   rd_idx,
	output pws_pkg::waiter_t            rd_data,
	input  pws_pkg::q_wr_t              wr
);

	pws_pkg::waiter_t entry_q [pws_pkg::QUEUE_DEPTH];

	always_ff @(posedge clk) begin
		if (wr.en) begin
			entry_q[wr.idx] <= wr.data;
		end
	end

	assign rd_data = entry_q[rd_idx];

endmodule

>>> hdl/pws_ctrl.sv
// Sequencer for the semaphore: count, waiter total and the entry-by-entry
// walk that inserts or compacts the wait queue. Depends on pws_pkg.
module pws_ctrl (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              in_valid,
	output logic                              in_ready,
	input  pws_pkg::func_t                    in_func,
	input  pws_pkg::waiter_t                  in_waiter,
	input  logic                              cfg_wr,
	input  logic [pws_pkg::COUNT_W-1:0]       cfg_count,
	output logic [pws_pkg::IDX_W-1:0]         rd_idx,
	input  pws_pkg::waiter_t                  rd_data,
	output pws_pkg::q_wr_t                    wr,
	output logic                              res_valid,
	input  logic                              res_ready,
	output pws_pkg::result_t                  res
);

	pws_pkg::state_t                   state_q, state_d;
	logic [pws_pkg::COUNT_W-1:0]       count_q;
	logic [pws_pkg::TOTAL_W-1:0]       total_q;
	logic [pws_pkg::IDX_W-1:0]         j_q;
	pws_pkg::waiter_t                  new_q;
	pws_pkg::waiter_t                  woken_q;
	pws_pkg::status_t                  status_q;
	logic                              accept;
	logic                              is_pend, is_try;
	logic                              count_zero;
	logic                              move_up;
	logic                              compact_last;

	assign accept       = in_valid && in_ready;
	assign is_pend      = (in_func == pws_pkg::FUNC_PEND);
	assign is_try       = (in_func == pws_pkg::FUNC_TRY_PEND);
	assign count_zero   = (count_q == '0);
	assign move_up      = (j_q != '0) && (new_q.prio < rd_data.prio);
	assign compact_last = (j_q == total_q[pws_pkg::IDX_W-1:0]);

	always_comb begin
		state_d = state_q;
		case (state_q)
			pws_pkg::S_IDLE: begin
				if (accept) begin
					if (is_pend && count_zero && (total_q != pws_pkg::TOTAL_FULL)) begin
						state_d = pws_pkg::S_INSERT;
					end else if (!is_pend && !is_try && (total_q > pws_pkg::TOTAL_W'(1))) begin
						state_d = pws_pkg::S_COMPACT;
					end else begin
						state_d = pws_pkg::S_DONE;
					end
				end
			end
			pws_pkg::S_INSERT: begin
				if (!move_up) begin
					state_d = pws_pkg::S_DONE;
				end
			end
			pws_pkg::S_COMPACT: begin
				if (compact_last) begin
					state_d = pws_pkg::S_DONE;
				end
			end
			pws_pkg::S_DONE: begin
				if (res_ready) begin
					state_d = pws_pkg::S_IDLE;
				end
			end
			default: state_d = pws_pkg::S_IDLE;
		endcase
	end

	always_comb begin
		in_ready  = 1'b0;
		res_valid = 1'b0;
		rd_idx    = '0;
		wr        = '0;
		case (state_q)
			pws_pkg::S_IDLE: begin
				in_ready = 1'b1;
			end
			pws_pkg::S_INSERT: begin
				rd_idx  = j_q - pws_pkg::IDX_W'(1);
				wr.en   = 1'b1;
				wr.idx  = j_q;
				wr.data = move_up ? rd_data : new_q;
			end
			pws_pkg::S_COMPACT: begin
				rd_idx  = j_q;
				wr.en   = 1'b1;
				wr.idx  = j_q - pws_pkg::IDX_W'(1);
				wr.data = rd_data;
			end
			pws_pkg::S_DONE: begin
				res_valid = 1'b1;
			end
			default: begin
				in_ready = 1'b0;
			end
		endcase
	end

	assign res.status      = status_q;
	assign res.woken       = woken_q;
	assign res.count_now   = count_q;
	assign res.waiters_now = total_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= pws_pkg::S_IDLE;
			count_q <= '0;
			total_q <= '0;
		end else begin
			state_q <= state_d;
			if (cfg_wr) begin
				count_q <= cfg_count;
				total_q <= '0;
			end else if (accept) begin
				if (is_pend || is_try) begin
					if (!count_zero) begin
						count_q <= count_q - pws_pkg::COUNT_W'(1);
					end
				end else if (total_q != '0) begin
					total_q <= total_q - pws_pkg::TOTAL_W'(1);
				end else if (count_q != pws_pkg::COUNT_MAX) begin
					count_q <= count_q + pws_pkg::COUNT_W'(1);
				end
			end else if (state_q == pws_pkg::S_INSERT && !move_up) begin
				total_q <= total_q + pws_pkg::TOTAL_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			new_q   <= in_waiter;
			woken_q <= '0;
			if (is_pend || is_try) begin
				j_q <= total_q[pws_pkg::IDX_W-1:0];
				if (!count_zero) begin
					status_q <= pws_pkg::ST_GRANTED;
				end else if (is_try) begin
					status_q <= pws_pkg::ST_TRY_FAILED;
				end else if (total_q == pws_pkg::TOTAL_FULL) begin
					status_q <= pws_pkg::ST_FULL;
				end else begin
					status_q <= pws_pkg::ST_QUEUED;
				end
			end else begin
				j_q <= pws_pkg::IDX_W'(1);
				if (total_q != '0) begin
					woken_q  <= rd_data;
					status_q <= pws_pkg::ST_WOKEN;
				end else if (count_q == pws_pkg::COUNT_MAX) begin
					status_q <= pws_pkg::ST_SATURATED;
				end else begin
					status_q <= pws_pkg::ST_RAISED;
				end
			end
		end else if (state_q == pws_pkg::S_INSERT && move_up) begin
			j_q <= j_q - pws_pkg::IDX_W'(1);
		end else if (state_q == pws_pkg::S_COMPACT) begin
			j_q <= j_q + pws_pkg::IDX_W'(1);
		end
	end

endmodule
